// ===== sv/system_register_trap_emulator_assert.svh =====
// ----------------------------------------------------------------------------
// System register trap emulator assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SYSTEM_REGISTER_TRAP_EMULATOR_ASSERT_SVH
`define SYSTEM_REGISTER_TRAP_EMULATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define SRTE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("srte assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define SRTE_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("srte assertion failed");

`else

`define SRTE_ASSERT(lbl, clk, rstn, prop)
`define SRTE_ASSERT_NEXT(lbl, clk, rstn, pre, post)

`endif

`endif

// ===== sv/srte_pkg.sv =====
// ----------------------------------------------------------------------------
// srte_pkg
// Types, encodings and the system register table of the trap emulator.
// ----------------------------------------------------------------------------
`default_nettype none

package srte_pkg;

  localparam int unsigned InsW    = 32;
  localparam int unsigned XW      = 64;
  localparam int unsigned RegIdxW = 5;
  localparam int unsigned NumSlot = 19;
  localparam int unsigned SlotW   = $clog2(NumSlot);

  localparam logic [SlotW-1:0] SlotPar  = SlotW'(17);
  localparam logic [SlotW-1:0] SlotDaif = SlotW'(18);

  localparam logic [InsW-1:0] DaifMask   = 32'hFFFF_F0FF;
  localparam logic [InsW-1:0] DaifSetOp  = 32'hD503_40DF;
  localparam logic [InsW-1:0] DaifClrOp  = 32'hD503_40FF;
  localparam logic [11:0]     TopMsr     = 12'hD51;
  localparam logic [11:0]     TopMrs     = 12'hD53;
  localparam logic [InsW-1:0] CodeMask   = 32'h000F_FFE0;
  localparam logic [InsW-1:0] TlbiOp     = 32'hD508_8708;
  localparam logic [InsW-1:0] DcLo       = 32'hD508_7620;
  localparam logic [InsW-1:0] DcHi       = 32'hD508_763E;
  localparam logic [InsW-1:0] AtLo       = 32'hD508_7800;
  localparam logic [InsW-1:0] AtHi       = 32'hD508_781E;
  localparam logic [XW-1:0]   CurrentLvl = 64'h4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_DAIF_SET,
    OP_DAIF_CLR,
    OP_READ,
    OP_WRITE,
    OP_NOP,
    OP_AT
  } srte_op_e;

  typedef struct packed {
    logic             hit;
    logic             perm_r;
    logic             perm_w;
    logic             is_const;
    logic [SlotW-1:0] slot;
  } srte_entry_t;

  typedef struct packed {
    srte_op_e         op;
    logic             is_const;
    logic [SlotW-1:0] slot;
    logic [3:0]       imm;
  } srte_dec_t;

  function automatic srte_entry_t sysreg_lookup(input logic [19:0] code);
    srte_entry_t e;
    e = '{hit: 1'b1, perm_r: 1'b1, perm_w: 1'b1, is_const: 1'b0, slot: '0};
    case (code)
      20'hBEFE0: e.slot = SlotW'(13);
      20'hB9E00: e.slot = SlotW'(16);
      20'hB9D00: e.slot = SlotW'(10);
      20'hB9C60: begin e.slot = SlotW'(11); e.perm_r = 1'b0; end
      20'hB9C40: begin e.slot = SlotW'(12); e.perm_r = 1'b0; end
      20'hB9C20: begin e.slot = SlotW'(14); e.perm_r = 1'b0; end
      20'hB9C00: e.slot = SlotW'(9);
      20'hB4220: e.slot = SlotDaif;
      20'h8D080: e.slot = SlotW'(8);
      20'h8C000: e.slot = SlotW'(7);
      20'h8A200: e.slot = SlotW'(6);
      20'h89E40: e.slot = SlotW'(15);
      20'h87400: begin e.slot = SlotPar; e.perm_w = 1'b0; end
      20'h84240: begin e.is_const = 1'b1; e.perm_w = 1'b0; end
      20'h84100: e.slot = SlotW'(0);
      20'h82040: e.slot = SlotW'(5);
      20'h82020: e.slot = SlotW'(4);
      20'h82000: e.slot = SlotW'(3);
      20'h81040: e.slot = SlotW'(2);
      20'h81000: e.slot = SlotW'(1);
      default: begin
        e.hit    = 1'b0;
        e.perm_r = 1'b0;
        e.perm_w = 1'b0;
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== sv/srte_in_if.sv =====
// ----------------------------------------------------------------------------
// srte_in_if
// Input channel: trapped instruction word and its Xt value.
// ----------------------------------------------------------------------------
`default_nettype none

interface srte_in_if;
  logic                            valid;
  logic                            ready;
  logic [srte_pkg::InsW-1:0]       instruction;
  logic [srte_pkg::XW-1:0]         source_value;

  modport source (output valid, output instruction, output source_value, input ready);
  modport sink   (input valid, input instruction, input source_value, output ready);
endinterface

`default_nettype wire

// ===== sv/srte_out_if.sv =====
// ----------------------------------------------------------------------------
// srte_out_if
// Result channel: handled flag and general register writeback.
// ----------------------------------------------------------------------------
`default_nettype none

interface srte_out_if;
  logic                            valid;
  logic                            ready;
  logic                            handled;
  logic                            reg_write;
  logic [srte_pkg::RegIdxW-1:0]    reg_index;
  logic [srte_pkg::XW-1:0]         reg_value;

  modport source (output valid, output handled, output reg_write, output reg_index,
                  output reg_value, input ready);
  modport sink   (input valid, input handled, input reg_write, input reg_index,
                  input reg_value, output ready);
endinterface

`default_nettype wire

// ===== sv/srte_decode.sv =====
// ----------------------------------------------------------------------------
// srte_decode
// Classifies a trapped instruction in priority order.
// ----------------------------------------------------------------------------
`default_nettype none

module srte_decode (
  input  logic [srte_pkg::InsW-1:0] instruction_i,
  output srte_pkg::srte_dec_t       dec_o
);
  import srte_pkg::*;

  logic [11:0]  top;
  logic [InsW-1:0] code_w;
  srte_entry_t  ent;

  assign top    = instruction_i[31:20];
  assign code_w = instruction_i & CodeMask;
  assign ent    = sysreg_lookup(code_w[19:0]);

  always_comb begin
    dec_o.op       = OP_NONE;
    dec_o.is_const = ent.is_const;
    dec_o.slot     = ent.slot;
    dec_o.imm      = instruction_i[11:8];

    if ((instruction_i & DaifMask) == DaifSetOp) begin
      dec_o.op = OP_DAIF_SET;
    end else if ((instruction_i & DaifMask) == DaifClrOp) begin
      dec_o.op = OP_DAIF_CLR;
    end else if (top == TopMrs && ent.hit && ent.perm_r) begin
      dec_o.op = OP_READ;
    end else if (top == TopMsr && ent.hit && ent.perm_w && !ent.is_const) begin
      dec_o.op = OP_WRITE;
    end else if (instruction_i == TlbiOp) begin
      dec_o.op = OP_NOP;
    end else if (instruction_i >= DcLo && instruction_i <= DcHi) begin
      dec_o.op = OP_NOP;
    end else if (instruction_i >= AtLo && instruction_i <= AtHi) begin
      dec_o.op = OP_AT;
    end
  end

endmodule

`default_nettype wire

// ===== sv/system_register_trap_emulator.sv =====
// ----------------------------------------------------------------------------
// system_register_trap_emulator
// Emulates trapped MRS/MSR, DAIF set/clear, TLBI, DC and AT instructions
// against a shadow system register file.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                        | transfer
//   --------+-----+------------------------------------------------+------------------
//   in_i    | in  | instruction[31:0], source_value[63:0]          | valid & ready
//   out_o   | out | handled, reg_write, reg_index[4:0], reg_value  | valid & ready
//
// One item per cycle sustained while results are taken. A result passes the input
// register, then the result register, before it is offered on out_o.
// Shadow writes commit as an item leaves the input register; the next item sees them.
// Reset clears all 19 shadow registers and both stage valids at once.
// A stalled result holds in the output register while one more item waits in the
// input register; input ready drops only when both are full and the result stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "system_register_trap_emulator_assert.svh"

module system_register_trap_emulator (
  input  logic       clk_i,
  input  logic       rst_ni,
  srte_in_if.sink    in_i,
  srte_out_if.source out_o
);
  import srte_pkg::*;

  // Input register stage
  logic            s1_valid_q;
  logic [InsW-1:0] s1_ins_q;
  logic [XW-1:0]   s1_xt_q;
  logic            s1_adv;
  logic            in_xfer;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               handled_q, handled_d;
  logic               reg_write_q, reg_write_d;
  logic [RegIdxW-1:0] reg_index_q, reg_index_d;
  logic [XW-1:0]      reg_value_q, reg_value_d;

  // Shadow system register file
  logic [XW-1:0] shadow_q [NumSlot];

  srte_dec_t dec;

  srte_decode u_decode (
    .instruction_i (s1_ins_q),
    .dec_o         (dec)
  );

  // The input stage moves on whenever the result register is free or drains.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_ins_q <= in_i.instruction;
      s1_xt_q  <= in_i.source_value;
    end
  end

  // Result fields; index and value are zero whenever there is no writeback
  always_comb begin
    handled_d   = (dec.op != OP_NONE);
    reg_write_d = (dec.op == OP_READ);
    reg_index_d = '0;
    reg_value_d = '0;
    if (dec.op == OP_READ) begin
      reg_index_d = s1_ins_q[RegIdxW-1:0];
      reg_value_d = dec.is_const ? CurrentLvl : shadow_q[dec.slot];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      handled_q   <= handled_d;
      reg_write_q <= reg_write_d;
      reg_index_q <= reg_index_d;
      reg_value_q <= reg_value_d;
    end
  end

  // Shadow file update, committed once per item as it leaves stage one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlot; i++) begin
        shadow_q[i] <= '0;
      end
    end else if (s1_adv) begin
      case (dec.op)
        OP_DAIF_SET: shadow_q[SlotDaif] <= shadow_q[SlotDaif] | XW'(dec.imm);
        OP_DAIF_CLR: shadow_q[SlotDaif] <= shadow_q[SlotDaif] & ~XW'(dec.imm);
        OP_WRITE:    shadow_q[dec.slot] <= s1_xt_q;
        OP_AT:       shadow_q[SlotPar]  <= s1_xt_q;
        default: ;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.handled   = handled_q;
  assign out_o.reg_write = reg_write_q;
  assign out_o.reg_index = reg_index_q;
  assign out_o.reg_value = reg_value_q;

  // A writeback is only ever reported for a handled instruction.
  `SRTE_ASSERT(a_wr_handled, clk_i, rst_ni, !out_valid_q || !reg_write_q || handled_q)
  // Without a writeback the index and value fields are zero.
  `SRTE_ASSERT(a_nowr_zero, clk_i, rst_ni,
               !out_valid_q || reg_write_q || (reg_index_q == '0 && reg_value_q == '0))
  // An item leaving stage one shows up as a valid result next cycle.
  `SRTE_ASSERT_NEXT(a_adv_out, clk_i, rst_ni, s1_adv, out_valid_q)
  // A stalled result is not overwritten.
  `SRTE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_o.ready,
                    out_valid_q && $stable(reg_value_q) && $stable(handled_q))

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the system register trap emulator. Directed
// instructions cover DAIF masking, the register table and its permissions,
// CurrentEL, the TLBI/DC no-ops and AT. Random traffic follows, with gaps
// on both channels, a gap-free run and a long result stall. A shadow-file
// predictor produces one expected result per instruction transfer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srte_pkg::*;

  localparam int unsigned NumSysreg    = 20;
  localparam int unsigned RxHoldCycles = 120;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned MaxPrinted   = 20;
  localparam longint      LimitNs      = 5_000_000;

  // Shadow slots, in the order the emulator keeps them.
  typedef enum logic [4:0] {
    SL_SP_EL0, SL_SCTLR_EL1, SL_CPACR_EL1, SL_TTBR0_EL1, SL_TTBR1_EL1,
    SL_TCR_EL1, SL_MAIR_EL1, SL_VBAR_EL1, SL_TPIDR_EL1, SL_PMCR_EL0,
    SL_PMCCNTR_EL0, SL_PMOVSCLR_EL0, SL_PMCNTENCLR_EL0, SL_PMCCFILTR_EL0,
    SL_PMCNTENSET_EL0, SL_PMINTENCLR_EL1, SL_PMUSERENR_EL0, SL_PAR_EL1, SL_DAIF
  } shadow_slot_e;

  // Encodings of bits 19:5 (op0..op2, low bits clear) used by directed tests.
  localparam logic [19:0] CodeCurrentEl = 20'h84240;
  localparam logic [19:0] CodeParEl1    = 20'h87400;
  localparam logic [19:0] CodeDaif      = 20'hB4220;
  localparam logic [19:0] CodePmovsclr  = 20'hB9C60;
  localparam logic [19:0] CodeSpEl0     = 20'h84100;
  localparam logic [19:0] CodeSctlrEl1  = 20'h81000;

  localparam logic [XW-1:0] AllOnes = '1;

  typedef struct packed {
    logic [19:0]  code;
    logic         can_read;
    logic         can_write;
    logic         reads_level;   // CurrentEL: constant, no slot behind it
    shadow_slot_e slot;
  } sysreg_desc_t;

  localparam sysreg_desc_t SysregMap [NumSysreg] = '{
    '{20'hBEFE0,    1'b1, 1'b1, 1'b0, SL_PMCCFILTR_EL0},
    '{20'hB9E00,    1'b1, 1'b1, 1'b0, SL_PMUSERENR_EL0},
    '{20'hB9D00,    1'b1, 1'b1, 1'b0, SL_PMCCNTR_EL0},
    '{CodePmovsclr, 1'b0, 1'b1, 1'b0, SL_PMOVSCLR_EL0},
    '{20'hB9C40,    1'b0, 1'b1, 1'b0, SL_PMCNTENCLR_EL0},
    '{20'hB9C20,    1'b0, 1'b1, 1'b0, SL_PMCNTENSET_EL0},
    '{20'hB9C00,    1'b1, 1'b1, 1'b0, SL_PMCR_EL0},
    '{CodeDaif,     1'b1, 1'b1, 1'b0, SL_DAIF},
    '{20'h8D080,    1'b1, 1'b1, 1'b0, SL_TPIDR_EL1},
    '{20'h8C000,    1'b1, 1'b1, 1'b0, SL_VBAR_EL1},
    '{20'h8A200,    1'b1, 1'b1, 1'b0, SL_MAIR_EL1},
    '{20'h89E40,    1'b1, 1'b1, 1'b0, SL_PMINTENCLR_EL1},
    '{CodeParEl1,   1'b1, 1'b0, 1'b0, SL_PAR_EL1},
    '{CodeCurrentEl,1'b1, 1'b0, 1'b1, SL_SP_EL0},
    '{CodeSpEl0,    1'b1, 1'b1, 1'b0, SL_SP_EL0},
    '{20'h82040,    1'b1, 1'b1, 1'b0, SL_TCR_EL1},
    '{20'h82020,    1'b1, 1'b1, 1'b0, SL_TTBR1_EL1},
    '{20'h82000,    1'b1, 1'b1, 1'b0, SL_TTBR0_EL1},
    '{20'h81040,    1'b1, 1'b1, 1'b0, SL_CPACR_EL1},
    '{CodeSctlrEl1, 1'b1, 1'b1, 1'b0, SL_SCTLR_EL1}
  };

  typedef struct packed {
    logic               handled;
    logic               reg_write;
    logic [RegIdxW-1:0] reg_index;
    logic [XW-1:0]      reg_value;
  } trap_result_t;

  logic clk_i;
  logic rst_ni;

  srte_in_if  in_if ();
  srte_out_if out_if ();

  system_register_trap_emulator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: our own copy of the shadow file.
  logic [XW-1:0] shadow_file [NumSlot];
  trap_result_t  expected_results [$];

  // Traffic shaping knobs, flipped by the test tasks.
  logic tx_idle_en;
  logic rx_idle_en;
  logic rx_hold;
  event rx_hold_start;

  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_emulated;
  int unsigned n_reads;
  int unsigned n_results;
  int unsigned n_input_stalls;

  // --------------------------------------------------------------------------
  // Clock and the run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(LimitNs);
    $display("system_register_trap_emulator: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor. Checks go in the emulator's priority order: DAIF set/clear,
  // then MRS/MSR through the table, then the TLBI/DC no-ops and AT.
  // --------------------------------------------------------------------------
  function automatic trap_result_t emulate_trap(input logic [InsW-1:0] ins,
                                                input logic [XW-1:0]   xt);
    trap_result_t r;
    logic [11:0]  top;
    logic [19:0]  code;
    int           hit;
    r    = '0;
    top  = ins[31:20];
    code = ins[19:0] & CodeMask[19:0];
    hit  = -1;
    n_sent++;

    if ((ins & DaifMask) == DaifSetOp) begin
      shadow_file[SL_DAIF] |= XW'(ins[11:8]);
      r.handled = 1'b1;
    end else if ((ins & DaifMask) == DaifClrOp) begin
      shadow_file[SL_DAIF] &= ~XW'(ins[11:8]);
      r.handled = 1'b1;
    end

    if (!r.handled && (top == TopMsr || top == TopMrs)) begin
      foreach (SysregMap[i]) if (SysregMap[i].code == code) hit = i;
      if (hit >= 0) begin
        // Wrong-direction access to a one-way register falls through unhandled.
        if (top == TopMrs && SysregMap[hit].can_read) begin
          r.handled   = 1'b1;
          r.reg_write = 1'b1;
          r.reg_index = ins[4:0];
          r.reg_value = SysregMap[hit].reads_level ? CurrentLvl
                                                   : shadow_file[SysregMap[hit].slot];
          n_reads++;
        end else if (top == TopMsr && SysregMap[hit].can_write &&
                     !SysregMap[hit].reads_level) begin
          shadow_file[SysregMap[hit].slot] = xt;
          r.handled = 1'b1;
        end
      end
    end

    if (!r.handled) begin
      if (ins == TlbiOp) begin
        r.handled = 1'b1;
      end else if (ins >= DcLo && ins <= DcHi) begin
        r.handled = 1'b1;
      end else if (ins >= AtLo && ins <= AtHi) begin
        shadow_file[SL_PAR_EL1] = xt;
        r.handled = 1'b1;
      end
    end

    if (r.handled) n_emulated++;
    return r;
  endfunction

  function automatic logic [InsW-1:0] sysreg_insn(input logic [11:0] top,
                                                  input logic [19:0] code,
                                                  input logic [4:0]  rt);
    return {top, code[19:5], rt};
  endfunction

  function automatic logic [InsW-1:0] daif_insn(input logic [InsW-1:0] op,
                                                input logic [3:0]      imm);
    return op | {20'b0, imm, 8'b0};
  endfunction

  // Mostly well-formed traps with random operands; some near misses and noise.
  function automatic logic [InsW-1:0] random_trap();
    int unsigned  pick;
    sysreg_desc_t d;
    logic [4:0]   rt;
    pick = $urandom_range(0, 99);
    d    = SysregMap[$urandom_range(0, NumSysreg - 1)];
    rt   = 5'($urandom);
    if (pick < 30) return sysreg_insn(TopMrs, d.code, rt);
    if (pick < 55) return sysreg_insn(TopMsr, d.code, rt);
    if (pick < 61) return daif_insn(DaifSetOp, 4'($urandom));
    if (pick < 67) return daif_insn(DaifClrOp, 4'($urandom));
    if (pick < 70) return TlbiOp;
    // one step past the top of each range lands on an unhandled word
    if (pick < 76) return DcLo + $urandom_range(0, int'(DcHi - DcLo) + 1);
    if (pick < 82) return AtLo + $urandom_range(0, int'(AtHi - AtLo) + 1);
    if (pick < 90) return {($urandom_range(0, 1) ? TopMrs : TopMsr), 15'($urandom), rt};
    return $urandom;
  endfunction

  function automatic logic [XW-1:0] random_xt();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return AllOnes;
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transfer per call. Valid is left high on return so a
  // following call can keep it up; idle cycles are the only place it drops.
  // --------------------------------------------------------------------------
  task automatic send_trap(input logic [InsW-1:0] ins, input logic [XW-1:0] xt);
    while (tx_idle_en && $urandom_range(0, 99) < 26) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.instruction  <= ins;
    in_if.source_value <= xt;
    forever begin
      @(posedge clk_i);
      if (in_if.ready) break;
      n_input_stalls++;
    end
    expected_results.push_back(emulate_trap(ins, xt));
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each transfer against the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [XW-1:0] got,
                                 input logic [XW-1:0] want);
    n_errors++;
    if (n_errors <= MaxPrinted)
      $display("%0t ns: %s: got 0x%0h, want 0x%0h", $realtime, field, got, want);
  endtask

  task automatic check_result();
    trap_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing outstanding", XW'(out_if.handled), '0);
      return;
    end
    want = expected_results.pop_front();
    n_results++;
    if (out_if.handled !== want.handled)
      report_mismatch("handled", XW'(out_if.handled), XW'(want.handled));
    if (out_if.reg_write !== want.reg_write)
      report_mismatch("reg_write", XW'(out_if.reg_write), XW'(want.reg_write));
    if (out_if.reg_index !== want.reg_index)
      report_mismatch("reg_index", XW'(out_if.reg_index), XW'(want.reg_index));
    if (out_if.reg_value !== want.reg_value)
      report_mismatch("reg_value", out_if.reg_value, want.reg_value);
  endtask

  // Sampling right after the edge sees pre-edge values of the block's outputs.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_if.valid && out_if.ready) check_result();
        out_if.ready <= !rx_hold && !(rx_idle_en && $urandom_range(0, 99) < 26);
      end
    end
  end

  // Long result stall, counted here so the sender keeps running meanwhile.
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(rx_hold_start);
      rx_hold <= 1'b1;
      repeat (RxHoldCycles) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------

  // Reset leaves every slot zero; CurrentEL is the constant level.
  task automatic test_reset_state();
    send_trap(sysreg_insn(TopMrs, CodeSctlrEl1, 5'd0), AllOnes);
    send_trap(sysreg_insn(TopMrs, CodeCurrentEl, 5'd7), AllOnes);
  endtask

  // DAIFSet ORs the immediate in, DAIFClr clears it; an MSR to DAIF sets
  // the upper bits, which the immediate forms never touch.
  task automatic test_daif_mask();
    send_trap(daif_insn(DaifSetOp, 4'hF), '0);
    send_trap(daif_insn(DaifClrOp, 4'h5), '0);
    send_trap(sysreg_insn(TopMrs, CodeDaif, 5'd1), '0);
    send_trap(daif_insn(DaifSetOp, 4'h0), '0);
    send_trap(sysreg_insn(TopMsr, CodeDaif, 5'd2), AllOnes);
    send_trap(daif_insn(DaifClrOp, 4'hF), '0);
    send_trap(sysreg_insn(TopMrs, CodeDaif, 5'd30), '0);
  endtask

  // Writes to read-only registers and reads of write-only ones are refused.
  task automatic test_access_permissions();
    send_trap(sysreg_insn(TopMsr, CodeCurrentEl, 5'd3), AllOnes);
    send_trap(sysreg_insn(TopMsr, CodeParEl1, 5'd4), AllOnes);
    send_trap(sysreg_insn(TopMsr, CodePmovsclr, 5'd5), AllOnes);
    send_trap(sysreg_insn(TopMrs, CodePmovsclr, 5'd6), '0);
    send_trap(sysreg_insn(TopMsr, CodeSpEl0, 5'd8), AllOnes);
    // register 31 is reported as is
    send_trap(sysreg_insn(TopMrs, CodeSpEl0, 5'd31), '0);
  endtask

  // TLBI and DC are no-ops; AT loads PAR. Words just past each range miss.
  task automatic test_maintenance_ops();
    send_trap(TlbiOp, '0);
    send_trap(DcHi, '0);
    send_trap(DcHi + 1, '0);
    send_trap(AtLo, 64'hA5A5_5A5A_0F0F_F0F0);
    send_trap(sysreg_insn(TopMrs, CodeParEl1, 5'd9), '0);
    send_trap(AtHi, AllOnes);
    send_trap(AtHi + 1, '0);
    send_trap(sysreg_insn(TopMrs, CodeParEl1, 5'd10), '0);
  endtask

  task automatic test_unknown_words();
    send_trap('0, AllOnes);
    send_trap('1, AllOnes);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_trap(random_trap(), random_xt());
  endtask

  // No gaps on either side: the block should take one item every cycle.
  task automatic test_back_to_back(input int unsigned count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (count) send_trap(random_trap(), random_xt());
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Results held off while the sender keeps pushing, so input ready must drop.
  task automatic test_result_backpressure(input int unsigned count);
    tx_idle_en = 1'b0;
    -> rx_hold_start;
    repeat (count) send_trap(random_trap(), random_xt());
    tx_idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.instruction  = '0;
    in_if.source_value = '0;
    tx_idle_en         = 1'b1;
    rx_idle_en         = 1'b1;
    n_errors           = 0;
    n_sent             = 0;
    n_emulated         = 0;
    n_reads            = 0;
    n_results          = 0;
    n_input_stalls     = 0;
    foreach (shadow_file[i]) shadow_file[i] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_daif_mask();
    test_access_permissions();
    test_maintenance_ops();
    test_unknown_words();
    test_random_traffic(520);
    test_back_to_back(150);
    test_result_backpressure(60);

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d trapped instructions: %0d emulated, %0d system register reads.",
             n_sent, n_emulated, n_reads);
    $display("Traffic had random gaps, a gap-free run and a %0d-cycle result stall (%0d input stalls).",
             RxHoldCycles, n_input_stalls);
    if (n_errors == 0) begin
      $display("system_register_trap_emulator: match");
    end else begin
      $display("system_register_trap_emulator: mismatch");
    end
    $finish;
  end

endmodule
